// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that prop holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Assert that an antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: src/ecpa_pkg.sv
// ----------------------------------------------------------------------------
// ecpa_pkg
// Types and codes shared by the prime-field point adder.
// ----------------------------------------------------------------------------
package ecpa_pkg;

   // Field width of every coordinate, register and result.
   localparam int unsigned W = 31;

   typedef struct packed {
      logic [W-1:0] first_x;
      logic [W-1:0] first_y;
      logic [W-1:0] second_x;
      logic [W-1:0] second_y;
   } req_type;

   typedef struct packed {
      logic [W-1:0] sum_x;
      logic [W-1:0] sum_y;
      logic         no_inverse;
   } rsp_type;

   localparam logic CSR_PRIME = 1'b0;
   localparam logic CSR_COEFF = 1'b1;

   // Arithmetic unit operations.
   typedef enum logic [2:0] {
      OP_MUL,
      OP_RED,
      OP_INV
   } op_type;

   // Arithmetic unit states.
   typedef enum logic [1:0] {
      U_IDLE,
      U_MUL,
      U_RED,
      U_INV
   } unit_state_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RED,
      ST_RED_WAIT,
      ST_SETUP,
      ST_SQ,
      ST_SQ_WAIT,
      ST_DEN,
      ST_INV,
      ST_INV_WAIT,
      ST_M,
      ST_M_WAIT,
      ST_MM,
      ST_MM_WAIT,
      ST_X3,
      ST_MY,
      ST_MY_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic   go;
      op_type op;
   } unit_ctl_type;

endpackage

// File: src/ecpa_unit.sv
// ----------------------------------------------------------------------------
// ecpa_unit
// Bit-serial modular arithmetic: multiply, reduce and binary inversion.
// ----------------------------------------------------------------------------
module ecpa_unit #(
   parameter int unsigned FIELD_BITS = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ecpa_pkg::unit_ctl_type  ctl,
   input  logic [FIELD_BITS-1:0]   p,
   input  logic [FIELD_BITS-1:0]   opa,
   input  logic [FIELD_BITS-1:0]   opb,
   output logic                    done,
   output logic                    fail,
   output logic [FIELD_BITS-1:0]   res
);

   localparam int unsigned N  = FIELD_BITS;
   localparam int unsigned CW = $clog2(2*N+2) + 1;

   ecpa_pkg::unit_state_type st_ff, st_in;
   logic [N:0]    acc_ff, acc_in;       // running value, one bit of headroom
   logic [N-1:0]  sh_ff, sh_in;         // shifting operand
   logic [N:0]    u_ff, u_in, v_ff, v_in;
   logic [N:0]    x1_ff, x1_in, x2_ff, x2_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_in, fail_in;
   logic [N-1:0]  res_in;

   logic [N+1:0] dbl, dsum;
   logic [N:0]   half1, half2, usub, vsub;

   // Halve modulo p: add p first when odd (p is odd).
   function automatic logic [N:0] halve(input logic [N:0] x, input logic [N-1:0] m);
      logic [N+1:0] t;
      begin
         t = x[0] ? ({1'b0, x} + {2'b0, m}) : {1'b0, x};
         halve = t[N+1:1];
      end
   endfunction

   always_comb begin
      st_in   = st_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      u_in    = u_ff;
      v_in    = v_ff;
      x1_in   = x1_ff;
      x2_in   = x2_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      fail_in = 1'b0;
      res_in  = acc_ff[N-1:0];
      dbl     = '0;
      dsum    = '0;
      half1   = '0;
      half2   = '0;
      usub    = '0;
      vsub    = '0;
      case (st_ff)
         ecpa_pkg::U_IDLE: begin
            if (ctl.go) begin
               cnt_in = '0;
               case (ctl.op)
                  ecpa_pkg::OP_MUL: begin
                     st_in  = ecpa_pkg::U_MUL;
                     acc_in = '0;
                     sh_in  = opb;
                  end
                  ecpa_pkg::OP_RED: begin
                     // Shift-in reduction of opa, one bit per cycle.
                     st_in  = ecpa_pkg::U_RED;
                     acc_in = '0;
                     sh_in  = opa;
                  end
                  ecpa_pkg::OP_INV: begin
                     st_in = ecpa_pkg::U_INV;
                     u_in  = {1'b0, opa};
                     v_in  = {1'b0, p};
                     x1_in = {{N{1'b0}}, 1'b1};
                     x2_in = '0;
                  end
                  default: st_in = ecpa_pkg::U_IDLE;
               endcase
            end
         end
         ecpa_pkg::U_MUL, ecpa_pkg::U_RED: begin
            // acc = 2*acc (+ bit when reducing, + opa when multiplying) mod p, acc below p.
            dbl = {acc_ff, 1'b0};
            if (st_ff == ecpa_pkg::U_RED) begin
               dbl[0] = sh_ff[N-1];
            end
            if (dbl >= {2'b0, p}) begin
               dbl = dbl - {2'b0, p};
            end
            dsum = dbl;
            if (st_ff == ecpa_pkg::U_MUL && sh_ff[N-1]) begin
               dsum = dbl + {2'b0, opa};
               if (dsum >= {2'b0, p}) begin
                  dsum = dsum - {2'b0, p};
               end
            end
            acc_in = dsum[N:0];
            sh_in  = {sh_ff[N-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(N-1)) begin
               st_in   = ecpa_pkg::U_IDLE;
               done_in = 1'b1;
               res_in  = dsum[N-1:0];
            end
         end
         ecpa_pkg::U_INV: begin
            // Binary extended GCD; x1*a = u, x2*a = v (mod p).
            if (u_ff == '0 || cnt_ff == CW'(2*N+1)) begin
               st_in   = ecpa_pkg::U_IDLE;
               done_in = 1'b1;
               fail_in = 1'b1;
               res_in  = '0;
            end else if (u_ff == {{N{1'b0}}, 1'b1}) begin
               st_in   = ecpa_pkg::U_IDLE;
               done_in = 1'b1;
               res_in  = x1_ff[N-1:0];
            end else if (v_ff == {{N{1'b0}}, 1'b1}) begin
               st_in   = ecpa_pkg::U_IDLE;
               done_in = 1'b1;
               res_in  = x2_ff[N-1:0];
            end else begin
               cnt_in = cnt_ff + 1'b1;
               half1  = halve(x1_ff, p);
               half2  = halve(x2_ff, p);
               if (!u_ff[0]) begin
                  u_in  = u_ff >> 1;
                  x1_in = half1;
                  cnt_in = cnt_ff;
               end else if (!v_ff[0]) begin
                  v_in  = v_ff >> 1;
                  x2_in = half2;
                  cnt_in = cnt_ff;
               end else if (u_ff >= v_ff) begin
                  usub  = u_ff - v_ff;
                  u_in  = usub;
                  x1_in = (x1_ff >= x2_ff) ? (x1_ff - x2_ff)
                                           : (x1_ff + {1'b0, p} - x2_ff);
               end else begin
                  vsub  = v_ff - u_ff;
                  v_in  = vsub;
                  x2_in = (x2_ff >= x1_ff) ? (x2_ff - x1_ff)
                                           : (x2_ff + {1'b0, p} - x1_ff);
               end
               // Both odd and equal above one means a common factor.
               if (u_ff[0] && v_ff[0] && u_ff == v_ff) begin
                  st_in   = ecpa_pkg::U_IDLE;
                  done_in = 1'b1;
                  fail_in = 1'b1;
                  res_in  = '0;
               end
            end
         end
         default: st_in = ecpa_pkg::U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ecpa_pkg::U_IDLE;
         done  <= 1'b0;
         fail  <= 1'b0;
      end else begin
         st_ff <= st_in;
         done  <= done_in;
         fail  <= fail_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      x1_ff  <= x1_in;
      x2_ff  <= x2_in;
      cnt_ff <= cnt_in;
      res    <= res_in;
   end

endmodule

// File: src/ec_point_add_prime_field.sv
// ----------------------------------------------------------------------------
// ec_point_add_prime_field
// Affine point addition on y^2 = x^3 + ax + b over a prime field.
// ----------------------------------------------------------------------------
// Channel  Ports                        Direction  Beat
// req      start, busy, req_data        in         start & !busy
// rsp      rsp_valid, rsp_data          out        rsp_valid, one cycle
// csr      csr_we, csr_index, csr_data  in         csr_we
//
// Five reductions and three products run through one shared bit-serial
// unit, a doubling adds a squaring, and the binary inversion runs there
// too; steps that do not use the unit sit between them. A modulus below
// three goes straight to the final state and ends in a flagged result.
// Reset is synchronous; the registers return to p = 2^31-1 and a = 0.
// busy stays high from the accepted beat until the result strobe.
// The receiver cannot stall; the result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ec_point_add_prime_field (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  ecpa_pkg::req_type        req_data,
   output logic                     rsp_valid,
   output ecpa_pkg::rsp_type        rsp_data,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [ecpa_pkg::W-1:0]   csr_data
);

   localparam int unsigned N = ecpa_pkg::W;

   ecpa_pkg::state_type state_ff, state_in;

   logic [N-1:0] p_ff, a_ff;
   // Working registers: reduced coordinates, coefficient and temporaries.
   logic [N-1:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic [N-1:0] ca_ff, ca_in, num_ff, num_in, den_ff, den_in, m_ff, m_in;
   logic [N-1:0] x3_ff, x3_in;
   logic [2:0]   ridx_ff, ridx_in;
   logic         bad_ff, bad_in;
   ecpa_pkg::rsp_type out_ff, out_in;
   logic         outv_ff, outv_in;

   ecpa_pkg::unit_ctl_type ctl;
   logic [N-1:0] opa, opb, ures;
   logic         udone, ufail;

   function automatic logic [N-1:0] msub(input logic [N-1:0] x, input logic [N-1:0] y,
                                          input logic [N-1:0] m);
      msub = (x >= y) ? (x - y) : (m - (y - x));
   endfunction

   function automatic logic [N-1:0] madd(input logic [N-1:0] x, input logic [N-1:0] y,
                                          input logic [N-1:0] m);
      logic [N:0] s;
      begin
         s = {1'b0, x} + {1'b0, y};
         if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
         end
         madd = s[N-1:0];
      end
   endfunction

   ecpa_unit #(.FIELD_BITS(N)) u_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .p     (p_ff),
      .opa   (opa),
      .opb   (opb),
      .done  (udone),
      .fail  (ufail),
      .res   (ures)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= N'(2147483647);
         a_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ecpa_pkg::CSR_PRIME: p_ff <= csr_data;
            ecpa_pkg::CSR_COEFF: a_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The value handed to the reducer for each of the five operands.
   logic [N-1:0] red_src;
   always_comb begin
      case (ridx_ff)
         3'd0:    red_src = x1_ff;
         3'd1:    red_src = y1_ff;
         3'd2:    red_src = x2_ff;
         3'd3:    red_src = y2_ff;
         default: red_src = ca_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      x1_in = x1_ff; y1_in = y1_ff; x2_in = x2_ff; y2_in = y2_ff;
      ca_in = ca_ff; num_in = num_ff; den_in = den_ff; m_in = m_ff;
      x3_in = x3_ff; ridx_in = ridx_ff; bad_in = bad_ff;
      out_in  = out_ff;
      outv_in = 1'b0;
      ctl.go  = 1'b0;
      ctl.op  = ecpa_pkg::OP_MUL;
      opa = red_src;
      opb = '0;
      case (state_ff)
         ecpa_pkg::ST_IDLE: begin
            if (start) begin
               x1_in = req_data.first_x;
               y1_in = req_data.first_y;
               x2_in = req_data.second_x;
               y2_in = req_data.second_y;
               ca_in = a_ff;
               ridx_in = '0;
               bad_in  = (p_ff < N'(3));
               state_in = (p_ff < N'(3)) ? ecpa_pkg::ST_DONE : ecpa_pkg::ST_RED;
            end
         end
         ecpa_pkg::ST_RED: begin
            ctl.go = 1'b1;
            ctl.op = ecpa_pkg::OP_RED;
            state_in = ecpa_pkg::ST_RED_WAIT;
         end
         ecpa_pkg::ST_RED_WAIT: begin
            if (udone) begin
               case (ridx_ff)
                  3'd0:    x1_in = ures;
                  3'd1:    y1_in = ures;
                  3'd2:    x2_in = ures;
                  3'd3:    y2_in = ures;
                  default: ca_in = ures;
               endcase
               ridx_in  = ridx_ff + 1'b1;
               state_in = (ridx_ff == 3'd4) ? ecpa_pkg::ST_SETUP : ecpa_pkg::ST_RED;
            end
         end
         ecpa_pkg::ST_SETUP: begin
            if (x1_ff == x2_ff && y1_ff == y2_ff) begin
               state_in = ecpa_pkg::ST_SQ;
            end else begin
               num_in = msub(y2_ff, y1_ff, p_ff);
               den_in = msub(x2_ff, x1_ff, p_ff);
               state_in = ecpa_pkg::ST_DEN;
            end
         end
         ecpa_pkg::ST_SQ: begin
            ctl.go = 1'b1;
            opa = x1_ff;
            opb = x1_ff;
            state_in = ecpa_pkg::ST_SQ_WAIT;
         end
         ecpa_pkg::ST_SQ_WAIT: begin
            opa = x1_ff;
            opb = x1_ff;
            if (udone) begin
               num_in = madd(madd(madd(ures, ures, p_ff), ures, p_ff), ca_ff, p_ff);
               den_in = madd(y1_ff, y1_ff, p_ff);
               state_in = ecpa_pkg::ST_DEN;
            end
         end
         ecpa_pkg::ST_DEN: begin
            if (den_ff == '0) begin
               bad_in   = 1'b1;
               state_in = ecpa_pkg::ST_DONE;
            end else begin
               state_in = ecpa_pkg::ST_INV;
            end
         end
         ecpa_pkg::ST_INV: begin
            ctl.go = 1'b1;
            ctl.op = ecpa_pkg::OP_INV;
            opa = den_ff;
            state_in = ecpa_pkg::ST_INV_WAIT;
         end
         ecpa_pkg::ST_INV_WAIT: begin
            if (udone) begin
               bad_in = ufail;
               den_in = ures;
               state_in = ufail ? ecpa_pkg::ST_DONE : ecpa_pkg::ST_M;
            end
         end
         ecpa_pkg::ST_M: begin
            ctl.go = 1'b1;
            opa = num_ff;
            opb = den_ff;
            state_in = ecpa_pkg::ST_M_WAIT;
         end
         ecpa_pkg::ST_M_WAIT: begin
            opa = num_ff;
            opb = den_ff;
            if (udone) begin
               m_in = ures;
               state_in = ecpa_pkg::ST_MM;
            end
         end
         ecpa_pkg::ST_MM: begin
            ctl.go = 1'b1;
            opa = m_ff;
            opb = m_ff;
            state_in = ecpa_pkg::ST_MM_WAIT;
         end
         ecpa_pkg::ST_MM_WAIT: begin
            opa = m_ff;
            opb = m_ff;
            if (udone) begin
               x3_in = msub(msub(ures, x1_ff, p_ff), x2_ff, p_ff);
               state_in = ecpa_pkg::ST_X3;
            end
         end
         ecpa_pkg::ST_X3: begin
            num_in = msub(x1_ff, x3_ff, p_ff);
            state_in = ecpa_pkg::ST_MY;
         end
         ecpa_pkg::ST_MY: begin
            ctl.go = 1'b1;
            opa = m_ff;
            opb = num_ff;
            state_in = ecpa_pkg::ST_MY_WAIT;
         end
         ecpa_pkg::ST_MY_WAIT: begin
            opa = m_ff;
            opb = num_ff;
            if (udone) begin
               m_in = msub(ures, y1_ff, p_ff);
               state_in = ecpa_pkg::ST_DONE;
            end
         end
         ecpa_pkg::ST_DONE: begin
            outv_in = 1'b1;
            out_in.no_inverse = bad_ff;
            out_in.sum_x = bad_ff ? '0 : x3_ff;
            out_in.sum_y = bad_ff ? '0 : m_ff;
            state_in = ecpa_pkg::ST_IDLE;
         end
         default: state_in = ecpa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecpa_pkg::ST_IDLE;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
      end
      x1_ff <= x1_in; y1_ff <= y1_in; x2_ff <= x2_in; y2_ff <= y2_in;
      ca_ff <= ca_in; num_ff <= num_in; den_ff <= den_in; m_ff <= m_in;
      x3_ff <= x3_in; ridx_ff <= ridx_in; bad_ff <= bad_in;
      out_ff <= out_in;
   end

   assign busy      = (state_ff != ecpa_pkg::ST_IDLE);
   assign rsp_valid = outv_ff;
   assign rsp_data  = out_ff;

   // The final state is always followed by a result strobe.
   `ASSERT_NEXT(a_strobe_after_done, clock, reset,
      state_ff == ecpa_pkg::ST_DONE, rsp_valid)
   // No strobe while work is still going on.
   `ASSERT_ALWAYS(a_no_strobe_busy, clock, reset,
      !(rsp_valid && state_ff != ecpa_pkg::ST_IDLE))
   // A flagged result carries zero coordinates.
   `ASSERT_ALWAYS(a_flag_zeros, clock, reset,
      !(rsp_valid && rsp_data.no_inverse) || (rsp_data.sum_x == '0 && rsp_data.sum_y == '0))

endmodule
